[rtl/odo_pkg.sv]
// Shared types, constants and the CORDIC arctangent table for the odometry block.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package odo_pkg;

   // CORDIC iteration count, clipped to the table length.
   localparam int TRIG_ITERATIONS = 16;
   localparam int TABLE_LEN = 24;
   localparam int ITER_COUNT = (TRIG_ITERATIONS > TABLE_LEN) ? TABLE_LEN : TRIG_ITERATIONS;
   localparam int CNT_W = (ITER_COUNT > 1) ? $clog2(ITER_COUNT) : 1;
   localparam int ATAN_IDX_W = $clog2(TABLE_LEN);

   // CORDIC datapath widths: vector components and the angle accumulator.
   localparam int CW = 37;
   localparam int ZW = 34;
   localparam int CORDIC_GAIN = 652032874;

   // Queue between the front and the back.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_BEARING = 2'd1;
   localparam logic [1:0] CMD_ERROR   = 2'd2;

   typedef enum logic [1:0] {
      CLS_TICK,
      CLS_BEARING,
      CLS_ERROR,
      CLS_NONE
   } cls_type;

   typedef enum logic {
      CM_ROTATE,
      CM_VECTOR
   } cordic_mode_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] left_position;
      logic signed [31:0] right_position;
      logic signed [15:0] gyro_yaw;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [15:0] target_heading;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] heading;
      logic signed [15:0] angle_answer;
      logic               saturated;
   } rsp_payload_type;

   typedef struct packed {
      cls_type            cls;
      logic signed [32:0] dc;
      logic signed [15:0] gyro_yaw;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [15:0] target_heading;
   } q_entry_type;

   typedef struct packed {
      logic            start;
      cordic_mode_type mode;
   } cordic_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_status_type;

   // Arctangent of 2^-idx in units where 2^31 equals pi.
   function automatic logic signed [ZW-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051E;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2F;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2FA;
         5'd15: val = 32'h0000517D;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A30;
         5'd19: val = 32'h00000518;
         5'd20: val = 32'h0000028C;
         5'd21: val = 32'h00000146;
         5'd22: val = 32'h000000A3;
         5'd23: val = 32'h00000051;
         default: val = 32'h0;
      endcase
      return {{(ZW-32){1'b0}}, val};
   endfunction

endpackage

`default_nettype wire

[rtl/odo_front.sv]
// Front end: accepts request transactions, classifies them, forms the wheel
// center delta against the stored last positions, and queues them. Uses odo_pkg.
`default_nettype none

module odo_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire odo_pkg::req_payload_type req_payload,
   output logic                          q_valid,
   input  wire logic                     q_pop,
   output odo_pkg::q_entry_type          q_head
);
   import odo_pkg::*;

   logic signed [31:0]   last_left_ff, last_left_in;
   logic signed [31:0]   last_right_ff, last_right_in;
   q_entry_type          queue_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push;
   cls_type              cls;
   logic signed [32:0]   delta_left;
   logic signed [32:0]   delta_right;
   logic signed [33:0]   delta_sum;
   logic signed [33:0]   sum_adj;
   q_entry_type          entry;

   assign req_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_head    = queue_ff[rd_ptr_ff];

   always_comb begin
      case (req_payload.cmd)
         CMD_TICK:    cls = CLS_TICK;
         CMD_BEARING: cls = CLS_BEARING;
         CMD_ERROR:   cls = CLS_ERROR;
         default:     cls = CLS_NONE;
      endcase
   end

   // The mean of the two deltas rounds toward zero, so odd negative sums get one added.
   always_comb begin
      delta_left  = {req_payload.left_position[31], req_payload.left_position}
                  - {last_left_ff[31], last_left_ff};
      delta_right = {req_payload.right_position[31], req_payload.right_position}
                  - {last_right_ff[31], last_right_ff};
      delta_sum   = {delta_left[32], delta_left} + {delta_right[32], delta_right};
      sum_adj     = delta_sum + {33'b0, delta_sum[33]};

      entry.cls            = cls;
      entry.dc             = sum_adj[33:1];
      entry.gyro_yaw       = req_payload.gyro_yaw;
      entry.target_x       = req_payload.target_x;
      entry.target_y       = req_payload.target_y;
      entry.target_heading = req_payload.target_heading;
   end

   always_comb begin
      last_left_in  = last_left_ff;
      last_right_in = last_right_ff;
      if (push && cls == CLS_TICK) begin
         last_left_in  = req_payload.left_position;
         last_right_in = req_payload.right_position;
      end

      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end

      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_left_ff  <= '0;
         last_right_ff <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         last_left_ff  <= last_left_in;
         last_right_ff <= last_right_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

[rtl/odo_cordic.sv]
// Iterative CORDIC unit, one micro-rotation per cycle, in rotation mode for
// sine and cosine or in vectoring mode for atan2. Uses odo_pkg.
`default_nettype none

module odo_cordic (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire odo_pkg::cordic_cmd_type       cmd,
   input  wire logic signed [odo_pkg::CW-1:0] x_init,
   input  wire logic signed [odo_pkg::CW-1:0] y_init,
   input  wire logic signed [odo_pkg::ZW-1:0] z_init,
   output odo_pkg::cordic_status_type         status,
   output logic signed [odo_pkg::CW-1:0]      x_out,
   output logic signed [odo_pkg::CW-1:0]      y_out,
   output logic signed [odo_pkg::ZW-1:0]      z_out
);
   import odo_pkg::*;

   cordic_mode_type      mode_ff, mode_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic signed [CW-1:0] x_ff, x_in;
   logic signed [CW-1:0] y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [CW-1:0] x_shift;
   logic signed [CW-1:0] y_shift;
   logic signed [ZW-1:0] atan_val;
   logic                 y_positive;
   logic                 ccw;

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

   // Rotation drives z toward zero, vectoring drives y toward zero.
   always_comb begin
      x_shift    = x_ff >>> cnt_ff;
      y_shift    = y_ff >>> cnt_ff;
      atan_val   = atan_entry(ATAN_IDX_W'(cnt_ff));
      y_positive = !y_ff[CW-1] && (|y_ff);
      ccw        = (mode_ff == CM_ROTATE) ? !z_ff[ZW-1] : !y_positive;
   end

   always_comb begin
      mode_in = mode_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (cmd.start) begin
         mode_in = cmd.mode;
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = x_init;
         y_in    = y_init;
         z_in    = z_init;
      end else if (busy_ff) begin
         if (ccw) begin
            x_in = x_ff - y_shift;
            y_in = y_ff + x_shift;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + y_shift;
            y_in = y_ff - x_shift;
            z_in = z_ff + atan_val;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ITER_COUNT - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         mode_ff <= CM_ROTATE;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   a_no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("CORDIC started while a run is in progress");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff)
      else $error("CORDIC run ended without a done pulse");

endmodule

`default_nettype wire

[rtl/odo_back.sv]
// Back end: holds the pose, sequences each queued transaction through the units its
// class needs (CORDIC, multiplier, saturating adder) and drives the result register.
// Uses odo_pkg; works with odo_front and odo_cordic.
`default_nettype none

module odo_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   output logic                               q_pop,
   input  wire odo_pkg::q_entry_type          q_head,
   output odo_pkg::cordic_cmd_type            cordic_cmd,
   output logic signed [odo_pkg::CW-1:0]      cordic_x_init,
   output logic signed [odo_pkg::CW-1:0]      cordic_y_init,
   output logic signed [odo_pkg::ZW-1:0]      cordic_z_init,
   input  wire odo_pkg::cordic_status_type    cordic_status,
   input  wire logic signed [odo_pkg::CW-1:0] cordic_x,
   input  wire logic signed [odo_pkg::CW-1:0] cordic_y,
   input  wire logic signed [odo_pkg::ZW-1:0] cordic_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output odo_pkg::rsp_payload_type           rsp_payload
);
   import odo_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_START = 8'b0000_0010,
      ST_WAIT  = 8'b0000_0100,
      ST_MUL_S = 8'b0000_1000,
      ST_ADD_X = 8'b0001_0000,
      ST_MUL_C = 8'b0010_0000,
      ST_ADD_Y = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
   localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(32'h4000_0000);

   state_type          state_ff, state_in;
   q_entry_type        item_ff, item_in;
   logic signed [31:0] x_pos_ff, x_pos_in;
   logic signed [31:0] y_pos_ff, y_pos_in;
   logic signed [15:0] heading_ff, heading_in;
   logic signed [15:0] answer_ff, answer_in;
   logic               sat_ff, sat_in;
   logic               flip_ff, flip_in;
   logic signed [64:0] prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic signed [32:0]   dc;
   logic signed [31:0]   tgt_x;
   logic signed [31:0]   tgt_y;
   logic signed [32:0]   dx;
   logic signed [32:0]   dy;
   logic                 head_flip;
   logic [15:0]          folded;
   logic signed [CW-1:0] trig_src;
   logic signed [CW-1:0] trig_neg;
   logic signed [31:0]   trig;
   logic signed [64:0]   prod_round;
   logic signed [34:0]   step;
   logic signed [31:0]   pos_sel;
   logic signed [35:0]   pos_sum;
   logic                 pos_ovf;
   logic signed [31:0]   pos_new;
   logic signed [ZW-1:0] z_round;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Sine/cosine fold: angles outside the right half-plane turn by pi and negate.
   always_comb begin
      dc        = item_ff.dc;
      tgt_x     = item_ff.target_x;
      tgt_y     = item_ff.target_y;
      dx        = {tgt_x[31], tgt_x} - {x_pos_ff[31], x_pos_ff};
      dy        = {tgt_y[31], tgt_y} - {y_pos_ff[31], y_pos_ff};
      head_flip = heading_ff[15] ^ heading_ff[14];
      folded    = {heading_ff[15] ^ head_flip, heading_ff[14:0]};

      trig_src   = (state_ff == ST_MUL_S) ? cordic_y : cordic_x;
      trig_neg   = flip_ff ? -trig_src : trig_src;
      trig       = trig_neg[31:0];
      prod_round = prod_ff + 65'sd536870912;
      step       = prod_round[64:30];
      pos_sel    = (state_ff == ST_ADD_X) ? x_pos_ff : y_pos_ff;
      pos_sum    = {{4{pos_sel[31]}}, pos_sel} + {step[34], step};
      pos_ovf    = (pos_sum[35:31] != 5'b00000) && (pos_sum[35:31] != 5'b11111);
      pos_new    = pos_ovf ? (pos_sum[35] ? POS_MIN : POS_MAX) : pos_sum[31:0];
      z_round    = cordic_z + ZW'(32'h8000);
   end

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      x_pos_in       = x_pos_ff;
      y_pos_in       = y_pos_ff;
      heading_in     = heading_ff;
      answer_in      = answer_ff;
      sat_in         = sat_ff;
      flip_in        = flip_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      q_pop          = 1'b0;
      cordic_cmd.start = 1'b0;
      cordic_cmd.mode  = CM_ROTATE;
      cordic_x_init    = CW'(CORDIC_GAIN);
      cordic_y_init    = '0;
      cordic_z_init    = {{(ZW-32){folded[15]}}, folded, 16'b0};

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_head;
               state_in = ST_START;
            end
         end
         ST_START: begin
            answer_in = '0;
            sat_in    = 1'b0;
            case (item_ff.cls)
               CLS_TICK: begin
                  flip_in          = head_flip;
                  cordic_cmd.start = 1'b1;
                  state_in         = ST_WAIT;
               end
               CLS_BEARING: begin
                  // A target on the robot has bearing zero.
                  if (dx == '0 && dy == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     cordic_cmd.start = 1'b1;
                     cordic_cmd.mode  = CM_VECTOR;
                     cordic_x_init    = CW'(dy);
                     cordic_y_init    = CW'(dx);
                     cordic_z_init    = '0;
                     if (dy[32]) begin
                        if (!dx[32]) begin
                           cordic_x_init = CW'(dx);
                           cordic_y_init = -CW'(dy);
                           cordic_z_init = QUARTER_TURN;
                        end else begin
                           cordic_x_init = -CW'(dx);
                           cordic_y_init = CW'(dy);
                           cordic_z_init = -QUARTER_TURN;
                        end
                     end
                     state_in = ST_WAIT;
                  end
               end
               CLS_ERROR: begin
                  answer_in = item_ff.target_heading - heading_ff;
                  state_in  = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_WAIT: begin
            if (cordic_status.done) begin
               if (item_ff.cls == CLS_TICK) begin
                  state_in = ST_MUL_S;
               end else begin
                  answer_in = z_round[31:16];
                  state_in  = ST_DONE;
               end
            end
         end
         ST_MUL_S: begin
            prod_in  = dc * trig;
            state_in = ST_ADD_X;
         end
         ST_ADD_X: begin
            x_pos_in = pos_new;
            sat_in   = sat_ff | pos_ovf;
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            prod_in  = dc * trig;
            state_in = ST_ADD_Y;
         end
         ST_ADD_Y: begin
            y_pos_in   = pos_new;
            sat_in     = sat_ff | pos_ovf;
            heading_in = item_ff.gyro_yaw;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.pos_x        = x_pos_ff;
               rsp_payload_in.pos_y        = y_pos_ff;
               rsp_payload_in.heading      = heading_ff;
               rsp_payload_in.angle_answer = answer_ff;
               rsp_payload_in.saturated    = sat_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         x_pos_ff     <= '0;
         y_pos_ff     <= '0;
         heading_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         x_pos_ff     <= x_pos_in;
         y_pos_ff     <= y_pos_in;
         heading_ff   <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      answer_ff      <= answer_in;
      sat_ff         <= sat_in;
      flip_ff        <= flip_in;
      prod_ff        <= prod_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.saturated |->
         rsp_payload_ff.pos_x == POS_MAX || rsp_payload_ff.pos_x == POS_MIN ||
         rsp_payload_ff.pos_y == POS_MAX || rsp_payload_ff.pos_y == POS_MIN)
      else $error("Saturation reported with both coordinates inside the range");

   a_sat_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.saturated |-> rsp_payload_ff.angle_answer == '0)
      else $error("Saturation reported together with a query answer");

   a_wait_has_cordic: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT |-> cordic_status.busy || cordic_status.done)
      else $error("Waiting on a CORDIC unit that is not running");

endmodule

`default_nettype wire

[rtl/differential_drive_odometry_top.sv]
// Top level of the differential-drive odometry block.
// Instantiates odo_front, odo_cordic and odo_back; uses odo_pkg.
`default_nettype none

// A tick transaction (cmd 0) updates x and y from the mean wheel travel and the
// previous heading, then takes the gyro yaw as the new heading; a bearing query
// (cmd 1) returns atan2 to a target point, and a heading query (cmd 2) returns the
// wrapped heading error. Every request gives exactly one response holding the pose
// after it. The back end handles one transaction at a time. A tick or a bearing
// query runs the iterative CORDIC unit, one micro-rotation per cycle; a heading
// query, a bearing to a target at the robot's own position or an unused code
// skips it. The back end takes each request out of the two-entry queue, which
// keeps accepting requests while it has room, even while the back end works or
// while a response waits for rsp_ready.
module differential_drive_odometry_top (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire odo_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output odo_pkg::rsp_payload_type      rsp_payload
);
   import odo_pkg::*;

   logic                 q_valid;
   logic                 q_pop;
   q_entry_type          q_head;
   cordic_cmd_type       cordic_cmd;
   cordic_status_type    cordic_status;
   logic signed [CW-1:0] cordic_x_init;
   logic signed [CW-1:0] cordic_y_init;
   logic signed [ZW-1:0] cordic_z_init;
   logic signed [CW-1:0] cordic_x;
   logic signed [CW-1:0] cordic_y;
   logic signed [ZW-1:0] cordic_z;

   odo_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_head      (q_head)
   );

   odo_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cordic_cmd),
      .x_init (cordic_x_init),
      .y_init (cordic_y_init),
      .z_init (cordic_z_init),
      .status (cordic_status),
      .x_out  (cordic_x),
      .y_out  (cordic_y),
      .z_out  (cordic_z)
   );

   odo_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_head        (q_head),
      .cordic_cmd    (cordic_cmd),
      .cordic_x_init (cordic_x_init),
      .cordic_y_init (cordic_y_init),
      .cordic_z_init (cordic_z_init),
      .cordic_status (cordic_status),
      .cordic_x      (cordic_x),
      .cordic_y      (cordic_y),
      .cordic_z      (cordic_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload)
   );

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for differential_drive_odometry_top: directed pose and
// query cases, then random phases under varied idling, checked against a local predictor.
// Depends on odo_pkg and the RTL under rtl/.
`default_nettype none

module tb;
   import odo_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int TRIG_STEPS = (TRIG_ITERATIONS > 24) ? 24 : TRIG_ITERATIONS;
   localparam longint GAIN_Q30 = 652032874;
   localparam longint POS_HI = 64'sd2147483647;
   localparam longint POS_LO = -64'sd2147483648;
   localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] POS_MIN = 32'sh80000000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 155;
   localparam int LIMIT_CYCLES = 500000;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   // Predicted pose, advanced once per accepted transaction.
   logic signed [31:0] pose_x = '0;
   logic signed [31:0] pose_y = '0;
   logic signed [31:0] wheel_left = '0;
   logic signed [31:0] wheel_right = '0;
   logic [15:0] pose_heading = '0;

   req_payload_type req_backlog [$];
   rsp_payload_type pose_reports_due [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_request = 1'b0;
   logic hold_taken = 1'b0;
   int stall_cycles_left = 0;

   int fault_count = 0;
   int response_count = 0;
   int clipped_count = 0;
   int tick_count = 0;
   int bearing_query_count = 0;
   int heading_query_count = 0;
   int unused_count = 0;

   differential_drive_odometry_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Arctangent of 2^-i, with 2^31 standing for pi.
   function automatic longint atan_q31(input int i);
      case (i)
         0:  return 64'h20000000;
         1:  return 64'h12E4051E;
         2:  return 64'h09FB385B;
         3:  return 64'h051111D4;
         4:  return 64'h028B0D43;
         5:  return 64'h0145D7E1;
         6:  return 64'h00A2F61E;
         7:  return 64'h00517C55;
         8:  return 64'h0028BE53;
         9:  return 64'h00145F2F;
         10: return 64'h000A2F98;
         11: return 64'h000517CC;
         12: return 64'h00028BE6;
         13: return 64'h000145F3;
         14: return 64'h0000A2FA;
         15: return 64'h0000517D;
         16: return 64'h000028BE;
         17: return 64'h0000145F;
         18: return 64'h00000A30;
         19: return 64'h00000518;
         20: return 64'h0000028C;
         21: return 64'h00000146;
         22: return 64'h000000A3;
         23: return 64'h00000051;
         default: return 64'h0;
      endcase
   endfunction

   function automatic void heading_sincos(input logic [15:0] ang, output longint sin_q30,
                                          output longint cos_q30);
      logic [31:0] a;
      logic [31:0] probe;
      logic flip;
      longint z, x, y, t;
      a = {ang, 16'h0000};
      probe = a + 32'h40000000;
      flip = probe[31];
      // Angles in the back half-plane are rotated by pi and the result negated.
      if (flip) a = a + 32'h80000000;
      z = longint'($signed(a));
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < TRIG_STEPS; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - atan_q31(i);
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + atan_q31(i);
         end
         x = t;
      end
      sin_q30 = flip ? -y : y;
      cos_q30 = flip ? -x : x;
   endfunction

   // Angle of the vector (dx, dy) measured from the y axis toward x.
   function automatic logic [15:0] bearing_to(input longint dx, input longint dy);
      longint bx, by, z, t, r;
      if (dx == 0 && dy == 0) return 16'h0000;
      bx = dy;
      by = dx;
      z = 0;
      if (bx < 0) begin
         if (by >= 0) begin
            t = by; by = -bx; bx = t; z = 64'sh40000000;
         end else begin
            t = -by; by = bx; bx = t; z = -64'sh40000000;
         end
      end
      for (int i = 0; i < TRIG_STEPS; i++) begin
         if (by > 0) begin
            t = bx + (by >>> i);
            by = by - (bx >>> i);
            z = z + atan_q31(i);
         end else begin
            t = bx - (by >>> i);
            by = by + (bx >>> i);
            z = z - atan_q31(i);
         end
         bx = t;
      end
      r = (z + 64'sd32768) >>> 16;
      return r[15:0];
   endfunction

   function automatic logic signed [31:0] clip_add(input logic signed [31:0] pos,
                                                   input longint step, output logic clipped);
      longint r;
      r = longint'(pos) + step;
      clipped = 1'b0;
      if (r > POS_HI) begin
         r = POS_HI;
         clipped = 1'b1;
      end
      if (r < POS_LO) begin
         r = POS_LO;
         clipped = 1'b1;
      end
      return r[31:0];
   endfunction

   function automatic rsp_payload_type odometry_update(input req_payload_type item);
      rsp_payload_type res;
      longint dl, dr, dc, s, c;
      logic clip_x, clip_y;
      logic [15:0] answer;
      answer = '0;
      clip_x = 1'b0;
      clip_y = 1'b0;
      case (item.cmd)
         CMD_TICK: begin
            dl = longint'($signed(item.left_position)) - longint'(wheel_left);
            dr = longint'($signed(item.right_position)) - longint'(wheel_right);
            dc = (dl + dr) / 2;
            // The move uses the heading from before this tick.
            heading_sincos(pose_heading, s, c);
            pose_x = clip_add(pose_x, (dc * s + 64'sh20000000) >>> 30, clip_x);
            pose_y = clip_add(pose_y, (dc * c + 64'sh20000000) >>> 30, clip_y);
            wheel_left = item.left_position;
            wheel_right = item.right_position;
            pose_heading = item.gyro_yaw;
         end
         CMD_BEARING: begin
            answer = bearing_to(longint'($signed(item.target_x)) - longint'(pose_x),
                                longint'($signed(item.target_y)) - longint'(pose_y));
         end
         CMD_ERROR: answer = item.target_heading - pose_heading;
         default: ;
      endcase
      res.pos_x = pose_x;
      res.pos_y = pose_y;
      res.heading = pose_heading;
      res.angle_answer = answer;
      res.saturated = clip_x | clip_y;
      return res;
   endfunction

   // Fields that the command does not use carry random content.
   function automatic req_payload_type make_item(input logic [1:0] cmd);
      req_payload_type it;
      it.cmd = cmd;
      it.left_position = $urandom;
      it.right_position = $urandom;
      it.gyro_yaw = 16'($urandom_range(65535));
      it.target_x = $urandom;
      it.target_y = $urandom;
      it.target_heading = 16'($urandom_range(65535));
      return it;
   endfunction

   function automatic void queue_tick(input logic signed [31:0] l, input logic signed [31:0] r,
                                      input logic signed [15:0] yaw);
      req_payload_type it;
      it = make_item(CMD_TICK);
      it.left_position = l;
      it.right_position = r;
      it.gyro_yaw = yaw;
      req_backlog.push_back(it);
   endfunction

   function automatic void queue_bearing(input logic signed [31:0] tx,
                                         input logic signed [31:0] ty);
      req_payload_type it;
      it = make_item(CMD_BEARING);
      it.target_x = tx;
      it.target_y = ty;
      req_backlog.push_back(it);
   endfunction

   function automatic void queue_error(input logic signed [15:0] th);
      req_payload_type it;
      it = make_item(CMD_ERROR);
      it.target_heading = th;
      req_backlog.push_back(it);
   endfunction

   task automatic drain();
      while (req_backlog.size() != 0 || req_valid || pose_reports_due.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin : request_drive
      if (req_valid && req_ready) begin
         pose_reports_due.push_back(odometry_update(req_payload));
         case (req_payload.cmd)
            CMD_TICK:    tick_count++;
            CMD_BEARING: bearing_query_count++;
            CMD_ERROR:   heading_query_count++;
            default:     unused_count++;
         endcase
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : response_check
      rsp_payload_type due_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            response_count++;
            if (rsp_payload.saturated) clipped_count++;
            if (pose_reports_due.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("response %0d arrived with no transaction pending", response_count);
            end else begin
               due_rsp = pose_reports_due.pop_front();
               if (rsp_payload.pos_x !== due_rsp.pos_x || rsp_payload.pos_y !== due_rsp.pos_y ||
                   rsp_payload.heading !== due_rsp.heading ||
                   rsp_payload.angle_answer !== due_rsp.angle_answer ||
                   rsp_payload.saturated !== due_rsp.saturated) begin
                  fault_count++;
                  if (fault_count <= MAX_REPORTS) begin
                     $display("response %0d mismatch: expected x %0d y %0d heading %0d ",
                              response_count, due_rsp.pos_x, due_rsp.pos_y, due_rsp.heading,
                              "answer %0d sat %0b", due_rsp.angle_answer, due_rsp.saturated);
                     $display("   actual x %0d y %0d heading %0d answer %0d sat %0b",
                              rsp_payload.pos_x, rsp_payload.pos_y, rsp_payload.heading,
                              rsp_payload.angle_answer, rsp_payload.saturated);
                  end
               end
            end
         end
         rsp_ready <= (stall_cycles_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // One long receiver hold-off so that the request side backs up.
   always @(posedge clock) begin : receiver_hold
      if (hold_request && !hold_taken) begin
         stall_cycles_left <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (stall_cycles_left != 0) begin
         stall_cycles_left <= stall_cycles_left - 1;
      end
   end

   initial begin : stimulus
      logic signed [31:0] gen_left, gen_right, snap_x, snap_y;
      logic [15:0] gen_yaw;
      int pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Queries against the reset pose, including a target straight behind.
      queue_bearing(0, 0);
      queue_bearing(0, -5000);
      queue_bearing(POS_MAX, POS_MIN);
      queue_error(16'sh8000);
      queue_error(16'sh7FFF);
      req_backlog.push_back(make_item(CMD_UNUSED));
      // Full-range wheel jumps drive both coordinates into their limits.
      queue_tick(POS_MAX, POS_MAX, -16'sd16384);
      queue_tick(POS_MIN, POS_MIN, 16'sh7FFF);
      queue_tick(POS_MAX, POS_MAX, 16'sh8000);
      queue_tick(POS_MIN, POS_MAX, 16'sd0);
      queue_tick(POS_MAX, POS_MIN, 16'sd16384);
      queue_bearing(POS_MIN, POS_MAX);
      queue_bearing(POS_MAX, POS_MAX);
      queue_error(16'sd0);
      // Odd wheel sums truncate toward zero in both directions.
      queue_tick(100, 100, 16'sd8192);
      queue_tick(99, 98, -16'sd8192);
      queue_tick(100, 100, 16'sd24576);
      req_backlog.push_back(make_item(CMD_UNUSED));
      drain();

      queue_bearing(pose_x, pose_y);
      queue_bearing(pose_x, pose_y - 1000);
      queue_bearing(pose_x - 1, pose_y - 1);
      drain();
      gen_left = wheel_left;
      gen_right = wheel_right;
      gen_yaw = pose_heading;

      @(negedge clock);
      hold_request = 1'b1;
      for (int k = 0; k < 20; k++) begin
         gen_left = gen_left + $urandom_range(400);
         gen_right = gen_right + $urandom_range(400);
         if (k % 2 == 0) queue_tick(gen_left, gen_right, gen_yaw + 16'd700);
         else queue_error(16'($urandom_range(65535)));
         gen_yaw = gen_yaw + 16'd700;
      end
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         @(negedge clock);
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         snap_x = pose_x;
         snap_y = pose_y;
         queue_bearing(snap_x, snap_y);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               // Mostly steady driving; now and then the encoders jump anywhere.
               if ($urandom_range(99) < 85) begin
                  gen_left = gen_left + $urandom_range(6000) - 1500;
                  gen_right = gen_right + $urandom_range(6000) - 1500;
                  gen_yaw = 16'(gen_yaw + $urandom_range(2000) - 1000);
               end else begin
                  gen_left = $urandom;
                  gen_right = $urandom;
                  gen_yaw = 16'($urandom_range(65535));
               end
               queue_tick(gen_left, gen_right, gen_yaw);
            end else if (pick < 80) begin
               if ($urandom_range(1) == 0)
                  queue_bearing(snap_x + $urandom_range(200000) - 100000,
                                snap_y + $urandom_range(200000) - 100000);
               else
                  queue_bearing($urandom, $urandom);
            end else if (pick < 95) begin
               queue_error(16'($urandom_range(65535)));
            end else begin
               req_backlog.push_back(make_item(CMD_UNUSED));
            end
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d transactions: %0d ticks, %0d bearing queries, %0d heading queries,",
               tick_count + bearing_query_count + heading_query_count + unused_count,
               tick_count, bearing_query_count, heading_query_count,
               " %0d unused codes", unused_count);
      $display("%0d responses checked, %0d with a clipped position, %0d failures",
               response_count, clipped_count, fault_count);
      if (fault_count == 0) begin
         $display("differential_drive_odometry_top regression: pass");
      end else begin
         $display("differential_drive_odometry_top regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * 20);
      $display("differential_drive_odometry_top regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
